[rtl/core/cst_pkg.sv]
package cst_pkg;

    localparam int LINE_BITS   = 16;
    localparam int OFFSET_BITS = 20;
    localparam int LEN_BITS    = 16;
    localparam int KIND_BITS   = 4;
    localparam int CHAR_BITS   = 8;

    // Queue between the scanner front end and the token sender.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int DIFF_W = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;

    typedef logic [KIND_BITS-1:0]   kind_t;
    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LEN_BITS-1:0]    length_t;
    typedef logic [CHAR_BITS-1:0]   char_t;

    localparam kind_t KIND_PLUS   = 4'd0;
    localparam kind_t KIND_MINUS  = 4'd1;
    localparam kind_t KIND_STAR   = 4'd2;
    localparam kind_t KIND_SLASH  = 4'd3;
    localparam kind_t KIND_EQUALS = 4'd4;
    localparam kind_t KIND_SEMI   = 4'd5;
    localparam kind_t KIND_LPAREN = 4'd6;
    localparam kind_t KIND_RPAREN = 4'd7;
    localparam kind_t KIND_LBRACE = 4'd8;
    localparam kind_t KIND_RBRACE = 4'd9;
    localparam kind_t KIND_NUMBER = 4'd10;
    localparam kind_t KIND_IDENT  = 4'd11;
    localparam kind_t KIND_END    = 4'd12;
    localparam kind_t KIND_BAD    = 4'd13;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_NL     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;
    localparam char_t CH_SEMI   = 8'h3B;
    localparam char_t CH_EQUALS = 8'h3D;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5A;
    localparam char_t CH_UNDER  = 8'h5F;
    localparam char_t CH_LO_A   = 8'h61;
    localparam char_t CH_LO_Z   = 8'h7A;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STOPPED
    } mode_t;

    typedef struct packed {
        kind_t   kind;
        line_t   line;
        line_t   column;
        offset_t offset;
        length_t length;
    } tok_t;

    // An event holds the one or two tokens that one scanned byte produces.
    typedef struct packed {
        logic two;
        tok_t tok0;
        tok_t tok1;
    } evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_decimal(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word_lead(input char_t c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    // Returns {hit, kind} for the single-character punctuators.
    function automatic logic [KIND_BITS:0] punct_lookup(input char_t c);
        logic [KIND_BITS:0] r;
        unique case (c)
            CH_PLUS:   r = {1'b1, KIND_PLUS};
            CH_MINUS:  r = {1'b1, KIND_MINUS};
            CH_STAR:   r = {1'b1, KIND_STAR};
            CH_SLASH:  r = {1'b1, KIND_SLASH};
            CH_EQUALS: r = {1'b1, KIND_EQUALS};
            CH_SEMI:   r = {1'b1, KIND_SEMI};
            CH_LPAREN: r = {1'b1, KIND_LPAREN};
            CH_RPAREN: r = {1'b1, KIND_RPAREN};
            CH_LBRACE: r = {1'b1, KIND_LBRACE};
            CH_RBRACE: r = {1'b1, KIND_RBRACE};
            default:   r = {1'b0, KIND_PLUS};
        endcase
        return r;
    endfunction

    function automatic line_t sat_inc_line(input line_t v);
        return (v == '1) ? v : v + line_t'(1);
    endfunction

    function automatic offset_t sat_inc_offset(input offset_t v);
        return (v == '1) ? v : v + offset_t'(1);
    endfunction

endpackage

[rtl/core/char_stream_tokenizer.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_source_char (one source byte)
// m_        out        m_valid / m_ready  token kind, line, column, offset, length, last
//
// One byte is taken per cycle while the token queue has room; a byte yields
// zero, one or two tokens, and the sender drives out one token per cycle while m_ready holds.
// A token is written into the queue and then into the output register before it appears on m_.
// The queue between scanner and sender lets either side stall on its own.
// Reset is synchronous on aresetn; no clearing pass.
module char_stream_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_line,
    output logic [15:0] m_token_column,
    output logic [19:0] m_token_offset,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);
    import cst_pkg::*;

    logic      push, pop;
    evt_t      push_evt, head_evt;
    q_status_t q_stat;

    cst_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_char (s_source_char),
        .q_stat        (q_stat),
        .push          (push),
        .push_evt      (push_evt)
    );

    cst_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_evt (push_evt),
        .pop      (pop),
        .head_evt (head_evt),
        .q_stat   (q_stat)
    );

    cst_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_evt       (head_evt),
        .q_stat         (q_stat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_line   (m_token_line),
        .m_token_column (m_token_column),
        .m_token_offset (m_token_offset),
        .m_token_length (m_token_length),
        .m_last_of_run  (m_last_of_run)
    );

    // The queue must never be written while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("token queue written while full");

    // The queue is never popped while empty.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("token queue popped while empty");

    // An end-of-source token carries no lexeme.
    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_token_kind == KIND_END) |-> (m_token_length == '0))
        else $error("end token with nonzero length");

    // A bad character is always the final token of its byte.
    a_bad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_token_kind == KIND_BAD) |-> m_last_of_run)
        else $error("bad-character token not marked last");

endmodule

[rtl/core/cst_front.sv]
module cst_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cst_pkg::char_t s_source_char,
    input  cst_pkg::q_status_t q_stat,
    output logic           push,
    output cst_pkg::evt_t  push_evt
);
    import cst_pkg::*;

    mode_t   mode_reg, mode_next;
    line_t   line_reg, line_next;
    line_t   col_reg, col_next;
    offset_t off_reg, off_next;
    line_t   run_line_reg, run_line_next;
    line_t   run_col_reg, run_col_next;
    offset_t run_off_reg, run_off_next;

    logic               accept;
    logic               emit_run, emit_cur, do_idle, restart, advance;
    kind_t              cur_kind;
    length_t            cur_len;
    logic [KIND_BITS:0] punct;
    logic [DIFF_W-1:0]  run_diff;
    length_t            run_len;
    tok_t               run_tok, cur_tok;
    char_t              c;

    assign c       = s_source_char;
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign punct   = punct_lookup(c);

    assign run_diff = DIFF_W'(off_reg) - DIFF_W'(run_off_reg);
    assign run_len  = (run_diff > DIFF_W'({LEN_BITS{1'b1}})) ? '1 : LEN_BITS'(run_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            line_reg     <= line_t'(1);
            col_reg      <= line_t'(1);
            off_reg      <= '0;
            run_line_reg <= line_t'(1);
            run_col_reg  <= line_t'(1);
            run_off_reg  <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            run_line_reg <= run_line_next;
            run_col_reg  <= run_col_next;
            run_off_reg  <= run_off_next;
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        off_next      = off_reg;
        run_line_next = run_line_reg;
        run_col_next  = run_col_reg;
        run_off_next  = run_off_reg;
        emit_run      = 1'b0;
        emit_cur      = 1'b0;
        do_idle       = 1'b0;
        restart       = 1'b0;
        advance       = 1'b0;
        cur_kind      = KIND_END;
        cur_len       = '0;

        unique case (mode_reg) inside
            MODE_STOPPED: begin
                if (c == CH_NUL) begin
                    emit_cur = 1'b1;
                    restart  = 1'b1;
                end
            end
            MODE_NUMBER, MODE_IDENT: begin
                if (is_decimal(c) || (mode_reg == MODE_IDENT && is_word_lead(c))) begin
                    advance = 1'b1;
                end else begin
                    emit_run  = 1'b1;
                    do_idle   = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // The byte that closes a run is scanned as if between tokens.
        if (do_idle) begin
            if (c == CH_NUL) begin
                emit_cur = 1'b1;
                restart  = 1'b1;
            end else if (is_blank(c)) begin
                advance = 1'b1;
            end else if (c == CH_NL) begin
                line_next = sat_inc_line(line_reg);
                col_next  = line_t'(1);
                off_next  = sat_inc_offset(off_reg);
            end else if (punct[KIND_BITS]) begin
                emit_cur = 1'b1;
                cur_kind = punct[KIND_BITS-1:0];
                cur_len  = length_t'(1);
                advance  = 1'b1;
            end else if (is_decimal(c) || is_word_lead(c)) begin
                mode_next     = is_decimal(c) ? MODE_NUMBER : MODE_IDENT;
                run_line_next = line_reg;
                run_col_next  = col_reg;
                run_off_next  = off_reg;
                advance       = 1'b1;
            end else begin
                emit_cur  = 1'b1;
                cur_kind  = KIND_BAD;
                cur_len   = length_t'(1);
                mode_next = MODE_STOPPED;
            end
        end

        if (advance) begin
            col_next = sat_inc_line(col_reg);
            off_next = sat_inc_offset(off_reg);
        end

        if (restart) begin
            mode_next     = MODE_IDLE;
            line_next     = line_t'(1);
            col_next      = line_t'(1);
            off_next      = '0;
            run_line_next = line_t'(1);
            run_col_next  = line_t'(1);
            run_off_next  = '0;
        end
    end

    always_comb begin
        run_tok.kind   = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        run_tok.line   = run_line_reg;
        run_tok.column = run_col_reg;
        run_tok.offset = run_off_reg;
        run_tok.length = run_len;

        cur_tok.kind   = cur_kind;
        cur_tok.line   = line_reg;
        cur_tok.column = col_reg;
        cur_tok.offset = off_reg;
        cur_tok.length = cur_len;

        push_evt.two  = emit_run && emit_cur;
        push_evt.tok0 = emit_run ? run_tok : cur_tok;
        push_evt.tok1 = cur_tok;
    end

    assign push = accept && (emit_run || emit_cur);

endmodule

[rtl/core/cst_queue.sv]
module cst_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cst_pkg::evt_t      push_evt,
    input  logic               pop,
    output cst_pkg::evt_t      head_evt,
    output cst_pkg::q_status_t q_stat
);
    import cst_pkg::*;

    evt_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head_evt     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

[rtl/core/cst_back.sv]
module cst_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cst_pkg::evt_t          head_evt,
    input  cst_pkg::q_status_t     q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_token_kind,
    output logic [15:0]            m_token_line,
    output logic [15:0]            m_token_column,
    output logic [19:0]            m_token_offset,
    output logic [15:0]            m_token_length,
    output logic                   m_last_of_run
);
    import cst_pkg::*;

    logic sel_reg, sel_next;
    logic m_valid_reg, m_valid_next;
    tok_t tok_reg;
    logic last_reg;
    logic out_free, load, is_last;
    tok_t cur_tok;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free && !q_stat.empty;
    assign cur_tok  = sel_reg ? head_evt.tok1 : head_evt.tok0;
    assign is_last  = !head_evt.two || sel_reg;
    assign pop      = load && is_last;

    always_comb begin
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = !q_stat.empty;
        end
        if (load) begin
            sel_next = !is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= cur_tok;
            last_reg <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_token_kind   = tok_reg.kind;
    assign m_token_line   = tok_reg.line;
    assign m_token_column = tok_reg.column;
    assign m_token_offset = tok_reg.offset;
    assign m_token_length = tok_reg.length;
    assign m_last_of_run  = last_reg;

endmodule

[sim/tb_top.sv]
module tb_top;

    import cst_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1400;
    localparam length_t LEN_TOP = '1;

    typedef struct {
        kind_t   kind;
        line_t   line;
        line_t   column;
        offset_t offset;
        length_t length;
        logic    last;
    } token_note_t;

    // Tracks the scanner position and holds the tokens still owed by the block.
    class token_tracker;
        token_note_t pending[$];
        int mismatches;
        int emitted;
        mode_t mode;
        line_t line_now, col_now, run_line, run_col;
        offset_t off_now, run_off;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode = MODE_IDLE;
            line_now = 1;
            col_now = 1;
            off_now = '0;
            run_line = 1;
            run_col = 1;
            run_off = '0;
        endfunction

        function void advance();
            col_now = (col_now == '1) ? col_now : col_now + 1'b1;
            off_now = (off_now == '1) ? off_now : off_now + 1'b1;
        endfunction

        function void emit(kind_t k, line_t l, line_t c, offset_t o, length_t n);
            token_note_t t;
            t.kind = k;
            t.line = l;
            t.column = c;
            t.offset = o;
            t.length = n;
            t.last = 1'b0;
            pending.push_back(t);
            emitted++;
        endfunction

        static function bit digit_char(char_t c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        static function bit word_lead(char_t c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                   c == CH_UNDER;
        endfunction

        static function bit blank_char(char_t c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR;
        endfunction

        static function bit punct_code(char_t c, output kind_t k);
            k = KIND_PLUS;
            case (c)
                CH_PLUS:   k = KIND_PLUS;
                CH_MINUS:  k = KIND_MINUS;
                CH_STAR:   k = KIND_STAR;
                CH_SLASH:  k = KIND_SLASH;
                CH_EQUALS: k = KIND_EQUALS;
                CH_SEMI:   k = KIND_SEMI;
                CH_LPAREN: k = KIND_LPAREN;
                CH_RPAREN: k = KIND_RPAREN;
                CH_LBRACE: k = KIND_LBRACE;
                CH_RBRACE: k = KIND_RBRACE;
                default:   return 1'b0;
            endcase
            return 1'b1;
        endfunction

        static function bit recognized(char_t c);
            kind_t k;
            return c == CH_NUL || c == CH_NL || blank_char(c) || digit_char(c) ||
                   word_lead(c) || punct_code(c, k);
        endfunction

        // Returns 0 when the byte is swallowed by the stopped scanner.
        function bit note_byte(char_t c);
            kind_t pk;
            offset_t span;
            token_note_t t;
            emitted = 0;
            if (mode == MODE_STOPPED) begin
                if (c != CH_NUL) return 1'b0;
                emit(KIND_END, line_now, col_now, off_now, '0);
                restart();
            end else begin
                if (mode != MODE_IDLE) begin
                    if (digit_char(c) || (mode == MODE_IDENT && word_lead(c))) begin
                        advance();
                        return 1'b1;
                    end
                    // The byte that ends a run is scanned again below.
                    span = off_now - run_off;
                    emit((mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT, run_line, run_col,
                         run_off, (span > offset_t'(LEN_TOP)) ? LEN_TOP : length_t'(span));
                    mode = MODE_IDLE;
                end
                if (c == CH_NUL) begin
                    emit(KIND_END, line_now, col_now, off_now, '0);
                    restart();
                end else if (blank_char(c)) begin
                    advance();
                end else if (c == CH_NL) begin
                    line_now = (line_now == '1) ? line_now : line_now + 1'b1;
                    col_now = 1;
                    off_now = (off_now == '1) ? off_now : off_now + 1'b1;
                end else if (punct_code(c, pk)) begin
                    emit(pk, line_now, col_now, off_now, length_t'(1));
                    advance();
                end else if (digit_char(c) || word_lead(c)) begin
                    mode = digit_char(c) ? MODE_NUMBER : MODE_IDENT;
                    run_line = line_now;
                    run_col = col_now;
                    run_off = off_now;
                    advance();
                end else begin
                    emit(KIND_BAD, line_now, col_now, off_now, length_t'(1));
                    mode = MODE_STOPPED;
                end
            end
            if (emitted > 0) begin
                t = pending.pop_back();
                t.last = 1'b1;
                pending.push_back(t);
            end
            return 1'b1;
        endfunction

        function void check_token(kind_t k, line_t l, line_t col, offset_t o, length_t n,
                                  logic lst);
            token_note_t e;
            if (pending.size() == 0) begin
                $error("unexpected token: kind %0d line %0d column %0d", k, l, col);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind) begin
                $error("token_kind expected %0d got %0d", e.kind, k);
                mismatches++;
            end
            if (l !== e.line) begin
                $error("token_line expected %0d got %0d", e.line, l);
                mismatches++;
            end
            if (col !== e.column) begin
                $error("token_column expected %0d got %0d", e.column, col);
                mismatches++;
            end
            if (o !== e.offset) begin
                $error("token_offset expected %0d got %0d", e.offset, o);
                mismatches++;
            end
            if (n !== e.length) begin
                $error("token_length expected %0d got %0d", e.length, n);
                mismatches++;
            end
            if (lst !== e.last) begin
                $error("last_of_run expected %0d got %0d", e.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_source_char = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [15:0] m_token_line;
    logic [15:0] m_token_column;
    logic [19:0] m_token_offset;
    logic [15:0] m_token_length;
    logic        m_last_of_run;

    token_tracker tracker;
    int burst_left = 0;
    int bytes_sent = 0;
    bit no_idle = 1'b0;
    int idle_cycles = 0;
    logic [31:0] rx_cycle;
    logic [15:0] stall_word;
    string opening_text = "+-*/=;(){}\t42z_\n\015Q";
    char_t punct_chars[10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUALS,
                               CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};

    char_stream_tokenizer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_char (s_source_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_line  (m_token_line),
        .m_token_column(m_token_column),
        .m_token_offset(m_token_offset),
        .m_token_length(m_token_length),
        .m_last_of_run (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    function automatic logic [15:0] next_stall_word();
        logic [15:0] w;
        case ($urandom_range(0, 3))
            0: w = '1;
            1: w = 16'($urandom);
            2: w = 16'($urandom) & 16'($urandom);
            default: w = 16'($urandom) | 16'($urandom);
        endcase
        return w | (16'h1 << $urandom_range(0, 15));
    endfunction

    function automatic char_t rand_word_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return CH_LO_A + char_t'(r);
        if (r < 52) return CH_UP_A + char_t'(r - 26);
        if (r == 52) return CH_UNDER;
        return CH_ZERO + char_t'(r - 53);
    endfunction

    function automatic char_t rand_bad_char();
        char_t c;
        do c = char_t'($urandom_range(1, 255)); while (token_tracker::recognized(c));
        return c;
    endfunction

    // Receiver: checks each token taken and stalls on its own pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= '0;
            stall_word <= '1;
        end else begin
            if (m_valid && m_ready) begin
                tracker.check_token(m_token_kind, m_token_line, m_token_column,
                                    m_token_offset, m_token_length, m_last_of_run);
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle[5:0] == 6'd0) stall_word <= next_stall_word();
            m_ready <= stall_word[rx_cycle[3:0]];
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_byte(input char_t c);
        int gap;
        s_valid <= 1'b1;
        s_source_char <= c;
        do @(posedge aclk); while (!s_ready);
        void'(tracker.note_byte(c));
        bytes_sent++;
        if (!no_idle) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 8);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge aclk);
    endtask

    // One lexical piece: mostly well-formed text, with rare bad bytes and noise.
    task automatic send_fragment();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_byte(rand_word_char(i == 0));
        end else if (pick < 46) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_byte(CH_ZERO + char_t'($urandom_range(0, 9)));
        end else if (pick < 66) begin
            send_byte(punct_chars[$urandom_range(0, 9)]);
        end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0: send_byte(CH_SPACE);
                    1: send_byte(CH_TAB);
                    default: send_byte(CH_CR);
                endcase
            end
        end else if (pick < 88) begin
            send_byte(CH_NL);
        end else if (pick < 93) begin
            send_byte(CH_NUL);
        end else if (pick < 96) begin
            send_byte(rand_bad_char());
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) send_byte(char_t'($urandom_range(1, 255)));
            send_byte(CH_NUL);
        end else begin
            send_byte(char_t'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Every punctuator, blanks, a number running into an identifier,
        // end of source closing a run, a bad byte closing a run, and the stopped state.
        for (int i = 0; i < opening_text.len(); i++) send_byte(char_t'(opening_text[i]));
        send_byte(CH_NUL);
        send_byte(CH_ZERO + char_t'(7));
        send_byte(8'hFF);
        send_byte(CH_LO_A);
        send_byte(CH_NUL);
        send_byte(CH_SPACE);
        send_byte(CH_NUL);
        drain_wait();

        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
            if ($urandom_range(0, 99) == 0) drain_wait();
            send_fragment();
        end

        drain_wait();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
